[rtl/core/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Shared codes and types for the sparse coordinate table: operation kinds,
// result status codes and the control group that drives the compare unit.
// ----------------------------------------------------------------------------
package sct_pkg;

	localparam int KIND_W   = 3;
	localparam int STATUS_W = 3;

	// Operation kinds carried by an input item
	localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CHANGE    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRANSPOSE = 3'd4;

	// Status codes returned with every result item
	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;

	// Control of the shared compare unit
	typedef struct packed {
		logic clr;  // zero the running maxima
		logic acc;  // fold the current read entry into the maxima
	} scan_ctl_t;

endpackage

[rtl/core/sparse_coordinate_table_core.sv]
// ----------------------------------------------------------------------------
// sparse_coordinate_table_core
// Coordinate list of nonzero matrix entries with insert, remove, change,
// lookup and transpose, reporting entry count and row and column maxima.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid, in_ready | kind, row_index, column_index, entry_value
//  out     | out_valid,out_ready| status, found, read_value, entry_count,
//          |                    | max_row, max_column
//
//  The store has a single read port and returns one entry per cycle.
//  An item is the find walk over the N stored entries, a move or swap walk
//  where needed, an insert step for an insert or change, the maxima walk
//  over the entries left and a last step that loads the result.
//  One item is in work at a time; in_ready is high only while idle.
//  A finished result waits in the output register, and the next item may be
//  accepted meanwhile; it only stalls at its end if the result is untaken.
//  Reset empties the table at once; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module sparse_coordinate_table_core #(
	parameter int CAPACITY   = 16,
	parameter int COORD_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sct_pkg::KIND_W-1:0]          kind,
	input  logic [COORD_BITS-1:0]               row_index,
	input  logic [COORD_BITS-1:0]               column_index,
	input  logic signed [VALUE_BITS-1:0]        entry_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sct_pkg::STATUS_W-1:0]        status,
	output logic                                found,
	output logic signed [VALUE_BITS-1:0]        read_value,
	output logic [$clog2(CAPACITY + 1)-1:0]     entry_count,
	output logic [COORD_BITS-1:0]               max_row,
	output logic [COORD_BITS-1:0]               max_column
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EW = 2 * COORD_BITS + VALUE_BITS;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FIND  = 7'b0000010,
		S_SHIFT = 7'b0000100,
		S_INS   = 7'b0001000,
		S_SWAP  = 7'b0010000,
		S_MAX   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                        state_q;
	logic [sct_pkg::KIND_W-1:0]    kind_q;
	logic [COORD_BITS-1:0]         key_row_q;
	logic [COORD_BITS-1:0]         key_col_q;
	logic [VALUE_BITS-1:0]         val_q;
	logic [CW-1:0]                 idx_q;
	logic                          pend_q;
	logic [AW-1:0]                 pend_idx_q;
	logic [CW-1:0]                 count_q;
	logic                          hit_q;
	logic [AW-1:0]                 slot_q;
	logic [VALUE_BITS-1:0]         hit_val_q;
	logic [sct_pkg::STATUS_W-1:0]  status_q;
	logic                          found_q;

	logic                          out_valid_q;
	logic [sct_pkg::STATUS_W-1:0]  out_status_q;
	logic                          out_found_q;
	logic [VALUE_BITS-1:0]         out_value_q;
	logic [CW-1:0]                 out_count_q;
	logic [COORD_BITS-1:0]         out_max_row_q;
	logic [COORD_BITS-1:0]         out_max_col_q;

	logic                          in_fire;
	logic                          scan_st;
	logic                          issue;
	logic                          scan_done;
	logic                          ins_bad;
	logic                          ins_full;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [EW-1:0]                 wr_data;
	logic [EW-1:0]                 rd_data;
	logic [COORD_BITS-1:0]         rd_row;
	logic [COORD_BITS-1:0]         rd_col;
	logic [VALUE_BITS-1:0]         rd_val;
	logic                          match;
	logic [COORD_BITS-1:0]         scan_max_row;
	logic [COORD_BITS-1:0]         scan_max_col;
	logic                          out_load;
	sct_pkg::scan_ctl_t            scan_ctl;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Walk the store one entry per cycle; read data returns in the following cycle
	assign scan_st   = (state_q == S_FIND) || (state_q == S_SHIFT) ||
	                   (state_q == S_SWAP) || (state_q == S_MAX);
	assign issue     = scan_st && (idx_q < count_q);
	assign scan_done = !issue && !pend_q;

	assign rd_row = rd_data[EW-1 -: COORD_BITS];
	assign rd_col = rd_data[VALUE_BITS +: COORD_BITS];
	assign rd_val = rd_data[VALUE_BITS-1:0];

	// Insert checks
	assign ins_bad  = (val_q == '0) || (key_row_q == '0) || (key_col_q == '0) || hit_q;
	assign ins_full = (count_q == CW'(CAPACITY));

	// Store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pend_idx_q;
		wr_data = rd_data;
		unique case (state_q)
			S_SHIFT: begin
				wr_en   = pend_q;
				wr_addr = pend_idx_q - AW'(1);
				wr_data = rd_data;
			end
			S_SWAP: begin
				wr_en   = pend_q;
				wr_addr = pend_idx_q;
				wr_data = {rd_col, rd_row, rd_val};
			end
			S_INS: begin
				wr_en   = !ins_bad && !ins_full;
				wr_addr = count_q[AW-1:0];
				wr_data = {key_row_q, key_col_q, val_q};
			end
			S_IDLE, S_FIND, S_MAX, S_DONE: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	sct_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.EW    (EW)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	assign scan_ctl.clr = in_fire;
	assign scan_ctl.acc = (state_q == S_MAX) && pend_q;

	sct_scan #(
		.COORD_BITS (COORD_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.rd_row  (rd_row),
		.rd_col  (rd_col),
		.key_row (key_row_q),
		.key_col (key_col_q),
		.match   (match),
		.max_row (scan_max_row),
		.max_col (scan_max_col)
	);

	// Capture the item
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q    <= kind;
			key_row_q <= row_index;
			key_col_q <= column_index;
			val_q     <= entry_value;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			count_q    <= '0;
			hit_q      <= 1'b0;
			slot_q     <= '0;
			hit_val_q  <= '0;
			status_q   <= sct_pkg::STAT_OK;
			found_q    <= 1'b0;
		end else begin
			// advance the read pointer in every walking phase
			pend_q     <= issue;
			pend_idx_q <= idx_q[AW-1:0];
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q  <= S_FIND;
						idx_q    <= '0;
						hit_q    <= 1'b0;
						found_q  <= 1'b0;
						status_q <= sct_pkg::STAT_OK;
					end
				end
				S_FIND: begin
					if (pend_q && match) begin
						hit_q     <= 1'b1;
						slot_q    <= pend_idx_q;
						hit_val_q <= rd_val;
					end
					if (scan_done) begin
						idx_q   <= '0;
						state_q <= S_MAX;
						unique case (kind_q)
							sct_pkg::KIND_INSERT: begin
								state_q <= S_INS;
							end
							sct_pkg::KIND_REMOVE: begin
								if (count_q == '0) begin
									status_q <= sct_pkg::STAT_EMPTY;
								end else if (!hit_q) begin
									status_q <= sct_pkg::STAT_MISSING;
								end else begin
									state_q <= S_SHIFT;
									idx_q   <= CW'(slot_q) + CW'(1);
								end
							end
							sct_pkg::KIND_CHANGE: begin
								if (hit_q) begin
									state_q <= S_SHIFT;
									idx_q   <= CW'(slot_q) + CW'(1);
								end else begin
									state_q <= S_INS;
								end
							end
							sct_pkg::KIND_LOOKUP: begin
								if (hit_q) begin
									found_q <= 1'b1;
								end else begin
									status_q <= sct_pkg::STAT_MISSING;
								end
							end
							sct_pkg::KIND_TRANSPOSE: begin
								if (count_q == '0) begin
									status_q <= sct_pkg::STAT_EMPTY;
								end else begin
									state_q <= S_SWAP;
								end
							end
							default: begin
								status_q <= sct_pkg::STAT_INVALID;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// later entries move down one slot; drop the last
					if (scan_done) begin
						count_q <= count_q - CW'(1);
						hit_q   <= 1'b0;
						idx_q   <= '0;
						state_q <= (kind_q == sct_pkg::KIND_CHANGE) ? S_INS : S_MAX;
					end
				end
				S_INS: begin
					if (ins_bad) begin
						status_q <= sct_pkg::STAT_INVALID;
					end else if (ins_full) begin
						status_q <= sct_pkg::STAT_FULL;
					end else begin
						count_q <= count_q + CW'(1);
					end
					idx_q   <= '0;
					state_q <= S_MAX;
				end
				S_SWAP: begin
					if (scan_done) begin
						idx_q   <= '0;
						state_q <= S_MAX;
					end
				end
				S_MAX: begin
					if (scan_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: load when empty or being drained
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q  <= status_q;
			out_found_q   <= found_q;
			out_value_q   <= found_q ? hit_val_q : '0;
			out_count_q   <= count_q;
			out_max_row_q <= scan_max_row;
			out_max_col_q <= scan_max_col;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign found       = out_found_q;
	assign read_value  = out_value_q;
	assign entry_count = out_count_q;
	assign max_row     = out_max_row_q;
	assign max_column  = out_max_col_q;

	// Table never holds more than its capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	// Count moves by at most one entry per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("entry count jumped");

	// A read in flight only exists inside a walking phase
	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> scan_st)
		else $error("read pending outside a walk");

	// An insert write never lands in a full table
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_INS) && wr_en) |-> (count_q < CW'(CAPACITY)))
		else $error("insert write into full table");

	// Found is reported only for a lookup that succeeded
	a_found_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> ((kind_q == sct_pkg::KIND_LOOKUP) && (status_q == sct_pkg::STAT_OK)))
		else $error("found set outside a lookup hit");

endmodule

[rtl/core/sct_mem.sv]
// ----------------------------------------------------------------------------
// sct_mem
// Entry store: one write port and one read port with registered read data.
// Each word packs row, column and value of one entry.
// ----------------------------------------------------------------------------
module sct_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int EW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [EW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [EW-1:0] rdata
);

	logic [EW-1:0] mem_q [DEPTH];
	logic [EW-1:0] rdata_q;

	// Write one word, read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/sct_scan.sv]
// ----------------------------------------------------------------------------
// sct_scan
// Shared compare unit: matches the entry read from the store against the
// requested position and keeps the running row and column maxima.
// ----------------------------------------------------------------------------
module sct_scan #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sct_pkg::scan_ctl_t    ctl,
	input  logic [COORD_BITS-1:0] rd_row,
	input  logic [COORD_BITS-1:0] rd_col,
	input  logic [COORD_BITS-1:0] key_row,
	input  logic [COORD_BITS-1:0] key_col,
	output logic                  match,
	output logic [COORD_BITS-1:0] max_row,
	output logic [COORD_BITS-1:0] max_col
);

	logic [COORD_BITS-1:0] max_row_q;
	logic [COORD_BITS-1:0] max_col_q;

	// Position compare
	assign match = (rd_row == key_row) && (rd_col == key_col);

	// Track largest row and column seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_row_q <= '0;
			max_col_q <= '0;
		end else if (ctl.clr) begin
			max_row_q <= '0;
			max_col_q <= '0;
		end else if (ctl.acc) begin
			if (rd_row > max_row_q) begin
				max_row_q <= rd_row;
			end
			if (rd_col > max_col_q) begin
				max_col_q <= rd_col;
			end
		end
	end

	assign max_row = max_row_q;
	assign max_col = max_col_q;

endmodule
